// File: rtl/fcce_pkg.sv
// Shared types, codes and helpers for the FAT12 cluster chain engine.
`default_nettype none

package fcce_pkg;

	// Operation codes on func
	localparam logic [2:0] FN_READ  = 3'd0;
	localparam logic [2:0] FN_WRITE = 3'd1;
	localparam logic [2:0] FN_ALLOC = 3'd2;
	localparam logic [2:0] FN_FREE  = 3'd3;
	localparam logic [2:0] FN_WALK  = 3'd4;

	// Result status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_ENDED  = 2'd2;
	localparam logic [1:0] ST_LIMIT  = 2'd3;

	// Configuration register indexes
	localparam logic CFG_FIRST_SECTOR = 1'b0;
	localparam logic CFG_CLUSTER_SECT = 1'b1;

	// Result word sources
	localparam logic [1:0] RES_ZERO  = 2'd0;
	localparam logic [1:0] RES_RDATA = 2'd1;
	localparam logic [1:0] RES_FND   = 2'd2;
	localparam logic [1:0] RES_CUR   = 2'd3;

	// Link encoding
	localparam int          LINK_W     = 12;
	localparam int          ADDR_W     = 20;
	localparam int          SCAN_W     = 13;
	localparam logic [11:0] LINK_EOC   = 12'hFFF;
	localparam logic [11:0] LINK_LIMIT = 12'hFF8;
	localparam logic [11:0] LINK_FIRST = 12'd2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic       load;
		logic       clr_wr;
		logic       rd_cur;
		logic       wr_word;
		logic       scan_start;
		logic       scan_run;
		logic       wr_eoc;
		logic       wr_link;
		logic       take_fnd;
		logic       free_step;
		logic       walk_adv;
		logic       from_zero;
		logic       from_cur;
		logic       mul;
		logic       fin;
		logic [1:0] fin_sel;
		logic [1:0] fin_st;
		logic       fin_addr;
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic cur_valid;
		logic rdata_valid;
		logic found;
		logic scan_done;
		logic from_ge2;
		logic steps_zero;
		logic cnt_full;
		logic clr_last;
	} sts_t;

	// A link that points at a data cluster
	function automatic logic link_ok(input logic [11:0] c);
		link_ok = (c >= LINK_FIRST) && (c < LINK_LIMIT);
	endfunction

endpackage

`default_nettype wire

// File: rtl/fcce_ctrl.sv
// Controller state machine of the FAT12 cluster chain engine.
`default_nettype none

module fcce_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [2:0]       func,
	input  wire logic             grow_chain,
	input  wire fcce_pkg::sts_t   sts,
	output fcce_pkg::cmd_t        cmd,
	output logic                  busy
);

	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_RD     = 5'd2;
	localparam logic [4:0] S_RDW    = 5'd3;
	localparam logic [4:0] S_WR     = 5'd4;
	localparam logic [4:0] S_FREE   = 5'd5;
	localparam logic [4:0] S_FREEW  = 5'd6;
	localparam logic [4:0] S_WSTART = 5'd7;
	localparam logic [4:0] S_WLOOP  = 5'd8;
	localparam logic [4:0] S_WCHK   = 5'd9;
	localparam logic [4:0] S_SCAN   = 5'd10;
	localparam logic [4:0] S_MARK   = 5'd11;
	localparam logic [4:0] S_LINK   = 5'd12;
	localparam logic [4:0] S_ADONE  = 5'd13;
	localparam logic [4:0] S_MUL    = 5'd14;
	localparam logic [4:0] S_ADD    = 5'd15;
	localparam logic [4:0] S_NOP    = 5'd16;

	logic [4:0] state_q;
	logic [4:0] state_d;
	logic [2:0] op_q;
	logic       grow_q;

	// Hold state and the latched operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			op_q    <= fcce_pkg::FN_READ;
			grow_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				op_q   <= func;
				grow_q <= grow_chain;
			end
		end
	end

	assign busy = (state_q != S_IDLE);

	// Sequence the operations
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					case (func)
						fcce_pkg::FN_READ:  state_d = S_RD;
						fcce_pkg::FN_WRITE: state_d = S_WR;
						fcce_pkg::FN_ALLOC: begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
						fcce_pkg::FN_FREE:  state_d = S_FREE;
						fcce_pkg::FN_WALK:  state_d = S_WSTART;
						default:            state_d = S_NOP;
					endcase
				end
			end
			S_RD: begin
				cmd.rd_cur = 1'b1;
				state_d    = S_RDW;
			end
			S_RDW: begin
				cmd.fin     = 1'b1;
				cmd.fin_sel = fcce_pkg::RES_RDATA;
				cmd.fin_st  = fcce_pkg::ST_OK;
				state_d     = S_IDLE;
			end
			S_WR: begin
				cmd.wr_word = 1'b1;
				cmd.fin     = 1'b1;
				cmd.fin_sel = fcce_pkg::RES_ZERO;
				cmd.fin_st  = fcce_pkg::ST_OK;
				state_d     = S_IDLE;
			end
			S_FREE: begin
				if (!sts.cur_valid) begin
					cmd.fin     = 1'b1;
					cmd.fin_sel = fcce_pkg::RES_ZERO;
					cmd.fin_st  = fcce_pkg::ST_OK;
					state_d     = S_IDLE;
				end else if (sts.cnt_full) begin
					cmd.fin     = 1'b1;
					cmd.fin_sel = fcce_pkg::RES_ZERO;
					cmd.fin_st  = fcce_pkg::ST_LIMIT;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_FREEW;
				end
			end
			S_FREEW: begin
				cmd.free_step = 1'b1;
				state_d       = S_FREE;
			end
			S_WSTART: begin
				if (sts.cur_valid) begin
					state_d = S_WLOOP;
				end else if (grow_q) begin
					cmd.from_zero  = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.fin     = 1'b1;
					cmd.fin_sel = fcce_pkg::RES_ZERO;
					cmd.fin_st  = fcce_pkg::ST_ENDED;
					state_d     = S_IDLE;
				end
			end
			S_WLOOP: begin
				if (sts.steps_zero) begin
					state_d = S_MUL;
				end else begin
					cmd.rd_cur = 1'b1;
					state_d    = S_WCHK;
				end
			end
			S_WCHK: begin
				if (sts.rdata_valid) begin
					cmd.walk_adv = 1'b1;
					state_d      = S_WLOOP;
				end else if (grow_q) begin
					cmd.from_cur   = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					cmd.fin     = 1'b1;
					cmd.fin_sel = fcce_pkg::RES_ZERO;
					cmd.fin_st  = fcce_pkg::ST_ENDED;
					state_d     = S_IDLE;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.found) begin
					state_d = S_MARK;
				end else if (sts.scan_done) begin
					cmd.fin     = 1'b1;
					cmd.fin_sel = fcce_pkg::RES_ZERO;
					cmd.fin_st  = fcce_pkg::ST_NOFREE;
					state_d     = S_IDLE;
				end
			end
			S_MARK: begin
				cmd.wr_eoc = 1'b1;
				state_d    = sts.from_ge2 ? S_LINK : S_ADONE;
			end
			S_LINK: begin
				cmd.wr_link = 1'b1;
				state_d     = S_ADONE;
			end
			S_ADONE: begin
				if (op_q == fcce_pkg::FN_ALLOC) begin
					cmd.fin     = 1'b1;
					cmd.fin_sel = fcce_pkg::RES_FND;
					cmd.fin_st  = fcce_pkg::ST_OK;
					state_d     = S_IDLE;
				end else begin
					cmd.take_fnd = 1'b1;
					state_d      = S_WLOOP;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.fin      = 1'b1;
				cmd.fin_sel  = fcce_pkg::RES_CUR;
				cmd.fin_st   = fcce_pkg::ST_OK;
				cmd.fin_addr = 1'b1;
				state_d      = S_IDLE;
			end
			S_NOP: begin
				cmd.fin     = 1'b1;
				cmd.fin_sel = fcce_pkg::RES_ZERO;
				cmd.fin_st  = fcce_pkg::ST_OK;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/fcce_dpath.sv
// Datapath of the FAT12 cluster chain engine: link table, pointers, address math.
`default_nettype none

module fcce_dpath #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int ALLOC_END     = 4080
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire fcce_pkg::cmd_t   cmd,
	output fcce_pkg::sts_t        sts,
	input  wire logic [11:0]      cluster_number,
	input  wire logic [11:0]      entry_word,
	input  wire logic [11:0]      link_steps,
	input  wire logic [6:0]       sector_in_cluster,
	input  wire logic             cfg_we,
	input  wire logic             cfg_index,
	input  wire logic [15:0]      cfg_wdata,
	output logic                  done,
	output logic [11:0]           result_word,
	output logic [19:0]           sector_address,
	output logic [1:0]            status
);

	localparam int IDX_W    = $clog2(TABLE_ENTRIES);
	localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
	localparam int SCAN_LIM = (ALLOC_END < TABLE_ENTRIES) ? ALLOC_END : TABLE_ENTRIES;
	localparam int SW       = fcce_pkg::SCAN_W;
	localparam int AW       = fcce_pkg::ADDR_W;

	logic [11:0]      mem [TABLE_ENTRIES];
	logic [11:0]      mem_rd_s1;
	logic             rd_oob_s1;
	logic [11:0]      rd_addr_s1;
	logic             rv_s1;

	logic [CNT_W-1:0] cnt_q;
	logic [SW-1:0]    scan_q;
	logic [11:0]      cur_q;
	logic [11:0]      from_q;
	logic [11:0]      steps_q;
	logic [11:0]      fnd_q;
	logic [11:0]      word_q;
	logic [6:0]       sic_q;
	logic [15:0]      fds_q;
	logic [7:0]       cs_q;
	logic [AW-1:0]    prod_s1;
	logic             done_q;
	logic [11:0]      res_q;
	logic [AW-1:0]    addr_q;
	logic [1:0]       st_q;

	logic [11:0]      rdata;
	logic             cur_oob;
	logic             from_oob;
	logic             scan_issue;
	logic             rd_en;
	logic [IDX_W-1:0] rd_idx;
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	logic [11:0]      wr_data;
	logic [11:0]      cur_m2;
	logic [AW-1:0]    addr_sum;
	logic [11:0]      res_d;

	assign rdata      = rd_oob_s1 ? 12'd0 : mem_rd_s1;
	assign cur_oob    = ({1'b0, cur_q} >= SW'(TABLE_ENTRIES));
	assign from_oob   = ({1'b0, from_q} >= SW'(TABLE_ENTRIES));
	assign scan_issue = cmd.scan_run && (scan_q < SW'(SCAN_LIM));

	// Status toward the controller
	assign sts.cur_valid   = fcce_pkg::link_ok(cur_q);
	assign sts.rdata_valid = fcce_pkg::link_ok(rdata);
	assign sts.found       = rv_s1 && (rdata == 12'd0);
	assign sts.scan_done   = !rv_s1 && (scan_q >= SW'(SCAN_LIM));
	assign sts.from_ge2    = (from_q >= fcce_pkg::LINK_FIRST);
	assign sts.steps_zero  = (steps_q == 12'd0);
	assign sts.cnt_full    = (cnt_q >= CNT_W'(TABLE_ENTRIES));
	assign sts.clr_last    = (cnt_q == CNT_W'(TABLE_ENTRIES - 1));

	// Select the read port address
	always_comb begin
		rd_en  = cmd.rd_cur || scan_issue;
		rd_idx = cmd.rd_cur ? cur_q[IDX_W-1:0] : scan_q[IDX_W-1:0];
	end

	// Select the write port; drop writes outside the table
	always_comb begin
		wr_en   = 1'b0;
		wr_idx  = cur_q[IDX_W-1:0];
		wr_data = 12'd0;
		if (cmd.clr_wr) begin
			wr_en  = 1'b1;
			wr_idx = cnt_q[IDX_W-1:0];
		end else if (cmd.wr_word) begin
			wr_en   = !cur_oob;
			wr_data = word_q;
		end else if (cmd.free_step) begin
			wr_en = !cur_oob;
		end else if (cmd.wr_eoc) begin
			wr_en   = 1'b1;
			wr_idx  = fnd_q[IDX_W-1:0];
			wr_data = fcce_pkg::LINK_EOC;
		end else if (cmd.wr_link) begin
			wr_en   = !from_oob;
			wr_idx  = from_q[IDX_W-1:0];
			wr_data = fnd_q;
		end
	end

	// Link table memory
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_s1  <= mem[rd_idx];
			rd_oob_s1  <= cmd.rd_cur && cur_oob;
			rd_addr_s1 <= scan_q[11:0];
		end
	end

	// Control registers: clear and free-step counter, scan tracking, config, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			rv_s1  <= 1'b0;
			scan_q <= '0;
			fds_q  <= 16'd33;
			cs_q   <= 8'd1;
			done_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.clr_wr || cmd.free_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.scan_start) begin
				scan_q <= SW'(2);
				rv_s1  <= 1'b0;
			end else if (cmd.scan_run) begin
				rv_s1 <= scan_issue;
				if (scan_issue) begin
					scan_q <= scan_q + SW'(1);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					fcce_pkg::CFG_FIRST_SECTOR: fds_q <= cfg_wdata;
					fcce_pkg::CFG_CLUSTER_SECT: cs_q  <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			done_q <= cmd.fin;
		end
	end

	assign cur_m2   = cur_q - fcce_pkg::LINK_FIRST;
	assign addr_sum = AW'(fds_q) + prod_s1 + AW'(sic_q);

	always_comb begin
		case (cmd.fin_sel)
			fcce_pkg::RES_ZERO:  res_d = 12'd0;
			fcce_pkg::RES_RDATA: res_d = rdata;
			fcce_pkg::RES_FND:   res_d = fnd_q;
			fcce_pkg::RES_CUR:   res_d = cur_q;
			default:             res_d = 12'd0;
		endcase
	end

	// Payload registers: pointers, latched request, product, result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= cluster_number;
			from_q  <= cluster_number;
			steps_q <= link_steps;
			word_q  <= entry_word;
			sic_q   <= sector_in_cluster;
		end else begin
			if (cmd.free_step) begin
				cur_q <= rdata;
			end else if (cmd.walk_adv) begin
				cur_q   <= rdata;
				steps_q <= steps_q - 12'd1;
			end else if (cmd.take_fnd) begin
				cur_q <= fnd_q;
				if (sts.from_ge2) begin
					steps_q <= steps_q - 12'd1;
				end
			end
			if (cmd.from_zero) begin
				from_q <= 12'd0;
			end else if (cmd.from_cur) begin
				from_q <= cur_q;
			end
		end
		if (cmd.scan_run && sts.found) begin
			fnd_q <= rd_addr_s1;
		end
		if (cmd.mul) begin
			prod_s1 <= AW'(cur_m2) * AW'(cs_q);
		end
		if (cmd.fin) begin
			res_q  <= res_d;
			st_q   <= cmd.fin_st;
			addr_q <= cmd.fin_addr ? addr_sum : '0;
		end
	end

	assign done           = done_q;
	assign result_word    = res_q;
	assign sector_address = addr_q;
	assign status         = st_q;

endmodule

`default_nettype wire

// File: rtl/fat12_cluster_chain_engine.sv
// Top level of the FAT12 cluster chain engine: controller plus datapath.
//
// Usage: pulse start with func and its operands while busy is low; the request
// is taken at that clock edge. One result per request comes back on
// result_word, sector_address and status, valid for the single cycle in which
// done is high. The receiver cannot stall, so a result is never held.
// Configuration (cfg_we, cfg_index, cfg_wdata) is written at any edge with
// cfg_we high; write it only while busy is low and no result is pending.
// Allocate scans for the first free entry, marks it end of chain and, when
// linked, writes the link; free clears one link per step; walk follows one
// link per step and, with grow_chain, grows the chain by a scan where it ends.
// Throughput is set by the single read port of the link table: a scan reads
// one entry per cycle, and each chain step reads one entry. A new request is
// taken only while busy is low.
// After reset the block clears the table with busy high; configuration
// returns to first_data_sector 33, cluster_sectors 1.
`default_nettype none

module fat12_cluster_chain_engine #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int ALLOC_END     = 4080
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  func,
	input  wire logic [11:0] cluster_number,
	input  wire logic [11:0] entry_word,
	input  wire logic [11:0] link_steps,
	input  wire logic        grow_chain,
	input  wire logic [6:0]  sector_in_cluster,
	output logic             done,
	output logic [11:0]      result_word,
	output logic [19:0]      sector_address,
	output logic [1:0]       status,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata
);

	fcce_pkg::cmd_t cmd;
	fcce_pkg::sts_t sts;

	fcce_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.func       (func),
		.grow_chain (grow_chain),
		.sts        (sts),
		.cmd        (cmd),
		.busy       (busy)
	);

	fcce_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.ALLOC_END     (ALLOC_END)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.cluster_number    (cluster_number),
		.entry_word        (entry_word),
		.link_steps        (link_steps),
		.sector_in_cluster (sector_in_cluster),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.done              (done),
		.result_word       (result_word),
		.sector_address    (sector_address),
		.status            (status)
	);

endmodule

`default_nettype wire

// File: rtl/fcce_checker.sv
// Port-level checker for the FAT12 cluster chain engine, bound to the top level.
`default_nettype none

module fcce_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [11:0] result_word,
	input wire logic [19:0] sector_address,
	input wire logic [1:0]  status
);

	// The block is busy in the cycle after it accepts a request
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// No result appears in the cycle right after acceptance
	a_accept_nodone: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> !done)
		else $error("result strobe right after accept");

	// Results never come in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("back-to-back result strobes");

	// The block is idle while a result is shown
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("busy while result shown");

	// A failed request returns zero payload
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status != fcce_pkg::ST_OK) |-> (result_word == 12'd0)
			&& (sector_address == 20'd0))
		else $error("failed request with nonzero payload");

endmodule

bind fat12_cluster_chain_engine fcce_checker u_fcce_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.result_word    (result_word),
	.sector_address (sector_address),
	.status         (status)
);

`default_nettype wire

// File: tb/fat12_cluster_chain_engine_tb.sv
// Self-checking testbench for the FAT12 cluster chain engine, with a table-tracking scoreboard.
`timescale 1ns / 1ps

module fat12_cluster_chain_engine_tb;

	localparam int TABLE_ENTRIES = 4096;
	localparam int ALLOC_END     = 4080;

	// Codes above the walk operation that the block must ignore
	localparam logic [2:0] FN_SPARE_FIRST = 3'd5;
	localparam logic [2:0] FN_SPARE_LAST  = 3'd7;

	typedef struct packed {
		logic [2:0]  func;
		logic [11:0] cluster;
		logic [11:0] word;
		logic [11:0] steps;
		logic        grow;
		logic [6:0]  sic;
	} request_t;

	typedef struct packed {
		logic [11:0] word;
		logic [19:0] addr;
		logic [1:0]  st;
	} result_t;

	// Tracks the link table and configuration, and holds the results still owed
	class link_table_checker;
		logic [11:0] links [TABLE_ENTRIES];
		logic [15:0] first_sector;
		logic [7:0]  sect_count;
		result_t     pending_results[$];
		int          mismatches;

		function new();
			foreach (links[i]) links[i] = 12'd0;
			first_sector = 16'd33;
			sect_count   = 8'd1;
			mismatches   = 0;
		endfunction

		function void set_register(logic idx, logic [15:0] data);
			if (idx == fcce_pkg::CFG_FIRST_SECTOR) begin
				first_sector = data;
			end else begin
				sect_count = data[7:0];
			end
		endfunction

		function bit is_link(logic [11:0] c);
			return (c >= fcce_pkg::LINK_FIRST) && (c < fcce_pkg::LINK_LIMIT);
		endfunction

		// First-fit claim of a free data cluster, optionally linked from another
		function logic [11:0] claim_free(logic [11:0] from);
			for (int c = 2; c < ALLOC_END && c < TABLE_ENTRIES; c++) begin
				if (links[c] == 12'd0) begin
					links[c] = fcce_pkg::LINK_EOC;
					if (from >= fcce_pkg::LINK_FIRST) links[from] = c[11:0];
					return c[11:0];
				end
			end
			return 12'd0;
		endfunction

		// Follow valid links from head, at most 64, and give the last cluster reached
		function int trace_chain(input logic [11:0] head, output logic [11:0] tail);
			logic [11:0] c;
			logic [11:0] nxt;
			int len;
			c = head;
			len = 0;
			while (len < 64) begin
				nxt = links[c];
				if (!is_link(nxt)) break;
				c = nxt;
				len++;
			end
			tail = c;
			return len;
		endfunction

		// Apply one accepted request to the table and queue the result it owes
		function result_t take_request(request_t rq);
			result_t     r;
			logic [11:0] c;
			logic [11:0] nxt;
			int          n;
			bit          ok;
			int unsigned sum;
			r = '0;
			r.st = fcce_pkg::ST_OK;
			case (rq.func)
				fcce_pkg::FN_READ: r.word = links[rq.cluster];
				fcce_pkg::FN_WRITE: links[rq.cluster] = rq.word;
				fcce_pkg::FN_ALLOC: begin
					r.word = claim_free(rq.cluster);
					if (r.word == 12'd0) r.st = fcce_pkg::ST_NOFREE;
				end
				fcce_pkg::FN_FREE: begin
					// Freed entries read back zero, so the limit needs a longer table than this
					c = rq.cluster;
					n = 0;
					while (is_link(c)) begin
						if (n >= TABLE_ENTRIES) begin
							r.st = fcce_pkg::ST_LIMIT;
							break;
						end
						nxt = links[c];
						links[c] = 12'd0;
						c = nxt;
						n++;
					end
				end
				fcce_pkg::FN_WALK: begin
					c = rq.cluster;
					ok = 1'b1;
					if (!is_link(c)) begin
						if (rq.grow) begin
							c = claim_free(12'd0);
							if (c == 12'd0) begin
								r.st = fcce_pkg::ST_NOFREE;
								ok = 1'b0;
							end
						end else begin
							r.st = fcce_pkg::ST_ENDED;
							ok = 1'b0;
						end
					end
					for (int i = 0; ok && i < int'(rq.steps); i++) begin
						nxt = links[c];
						if (!is_link(nxt)) begin
							if (rq.grow) begin
								nxt = claim_free(c);
								if (nxt == 12'd0) begin
									r.st = fcce_pkg::ST_NOFREE;
									ok = 1'b0;
								end
							end else begin
								r.st = fcce_pkg::ST_ENDED;
								ok = 1'b0;
							end
						end
						c = nxt;
					end
					if (ok) begin
						r.word = c;
						sum = int'(first_sector) + (int'(c) - 2) * int'(sect_count)
							+ int'(rq.sic);
						r.addr = sum[19:0];
					end
				end
				default: r = '0;
			endcase
			pending_results.push_back(r);
			return r;
		endfunction

		task flag_mismatch(string what, int unsigned got_v, int unsigned want_v);
			$display("%0t MISMATCH %s: got %0h expected %0h", $time, what, got_v, want_v);
			mismatches++;
		endtask

		// Compare one result with the oldest one owed
		task check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				flag_mismatch("result with no request", 32'(got.word), 0);
				return;
			end
			want = pending_results.pop_front();
			if (got.word !== want.word)
				flag_mismatch("result_word", 32'(got.word), 32'(want.word));
			if (got.addr !== want.addr)
				flag_mismatch("sector_address", 32'(got.addr), 32'(want.addr));
			if (got.st !== want.st)
				flag_mismatch("status", 32'(got.st), 32'(want.st));
		endtask
	endclass

	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        start             = 1'b0;
	logic [2:0]  func              = 3'd0;
	logic [11:0] cluster_number    = 12'd0;
	logic [11:0] entry_word        = 12'd0;
	logic [11:0] link_steps        = 12'd0;
	logic        grow_chain        = 1'b0;
	logic [6:0]  sector_in_cluster = 7'd0;
	logic        cfg_we            = 1'b0;
	logic        cfg_index         = 1'b0;
	logic [15:0] cfg_wdata         = 16'd0;
	logic        busy;
	logic        done;
	logic [11:0] result_word;
	logic [19:0] sector_address;
	logic [1:0]  status;

	link_table_checker board = new();
	logic [11:0]       chain_heads[$];
	int                idle_pct = 0;

	fat12_cluster_chain_engine #(
		.TABLE_ENTRIES(TABLE_ENTRIES),
		.ALLOC_END(ALLOC_END)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.cluster_number(cluster_number),
		.entry_word(entry_word),
		.link_steps(link_steps),
		.grow_chain(grow_chain),
		.sector_in_cluster(sector_in_cluster),
		.done(done),
		.result_word(result_word),
		.sector_address(sector_address),
		.status(status),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// Check every strobed result at the edge that ends its cycle
	always @(posedge clk) begin
		result_t seen;
		if (arst_n && done === 1'b1) begin
			seen.word = result_word;
			seen.addr = sector_address;
			seen.st   = status;
			board.check_result(seen);
		end
	end

	// Issue one request, idling first at the current rate, and hold it until taken
	task automatic send_request(input request_t rq, output result_t predicted);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start             <= 1'b1;
		func              <= rq.func;
		cluster_number    <= rq.cluster;
		entry_word        <= rq.word;
		link_steps        <= rq.steps;
		grow_chain        <= rq.grow;
		sector_in_cluster <= rq.sic;
		do @(posedge clk); while (busy !== 1'b0);
		predicted = board.take_request(rq);
	endtask

	task automatic directed_request(logic [2:0] f, logic [11:0] cl, logic [11:0] wd,
			logic [11:0] n, logic g, logic [6:0] s);
		request_t rq;
		result_t  res;
		rq = '{f, cl, wd, n, g, s};
		send_request(rq, res);
	endtask

	// Drop start and wait until every owed result is in and the block is idle
	task automatic wait_all_results();
		start <= 1'b0;
		while (board.pending_results.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	task automatic write_registers(logic [15:0] first_val, logic [15:0] sect_val);
		wait_all_results();
		cfg_we    <= 1'b1;
		cfg_index <= fcce_pkg::CFG_FIRST_SECTOR;
		cfg_wdata <= first_val;
		@(posedge clk);
		board.set_register(fcce_pkg::CFG_FIRST_SECTOR, first_val);
		cfg_index <= fcce_pkg::CFG_CLUSTER_SECT;
		cfg_wdata <= sect_val;
		@(posedge clk);
		board.set_register(fcce_pkg::CFG_CLUSTER_SECT, sect_val);
		cfg_we <= 1'b0;
	endtask

	function automatic request_t noise_request();
		request_t rq;
		rq.func    = fcce_pkg::FN_READ;
		rq.cluster = 12'($urandom_range(4095));
		rq.word    = 12'($urandom_range(4095));
		rq.steps   = 12'($urandom_range(4095));
		rq.grow    = 1'($urandom_range(1));
		rq.sic     = 7'($urandom_range(127));
		return rq;
	endfunction

	// Edge cases on a freshly cleared table at reset configuration
	task automatic directed_part();
		directed_request(fcce_pkg::FN_READ, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_READ, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 7'h7F);
		directed_request(fcce_pkg::FN_WRITE, 12'd0, 12'hFFF, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_READ, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WRITE, 12'd1, 12'hABC, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_READ, 12'd1, 12'd0, 12'd0, 1'b0, 7'd0);
		// build chain 2 -> 3 -> 4
		directed_request(fcce_pkg::FN_ALLOC, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_ALLOC, 12'd2, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_ALLOC, 12'd3, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'd2, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'd2, 12'd0, 12'd2, 1'b0, 7'h7F);
		directed_request(fcce_pkg::FN_WALK, 12'd2, 12'd0, 12'd5, 1'b0, 7'd3);
		directed_request(fcce_pkg::FN_WALK, 12'd2, 12'd0, 12'd4, 1'b1, 7'd9);
		// invalid starts: ended without growth, new head with it
		directed_request(fcce_pkg::FN_WALK, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'hFFF, 12'd0, 12'd1, 1'b1, 7'd1);
		// allocation linked from the very cluster it finds
		directed_request(fcce_pkg::FN_ALLOC, 12'd9, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_READ, 12'd9, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'd9, 12'd0, 12'hFFF, 1'b0, 7'd5);
		directed_request(fcce_pkg::FN_FREE, 12'd2, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_READ, 12'd4, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_FREE, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_FREE, 12'hFF8, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(FN_SPARE_FIRST, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, 7'h7F);
		directed_request(FN_SPARE_LAST, 12'd5, 12'd5, 12'd5, 1'b0, 7'd5);
		directed_request(fcce_pkg::FN_FREE, 12'd9, 12'd0, 12'd0, 1'b0, 7'd0);
	endtask

	// Mostly well-formed chain work on tracked heads, with noise mixed in
	task automatic random_item();
		request_t    rq;
		result_t     res;
		logic [11:0] tail;
		logic [11:0] head;
		int          pick;
		int          slot;
		int          len;
		rq   = noise_request();
		pick = $urandom_range(99);
		if (chain_heads.size() > 24 && pick < 60) pick = 60;
		if (chain_heads.size() == 0 && pick >= 15 && pick < 70) pick = 0;
		slot = 0;
		len  = 0;
		tail = 12'($urandom_range(4095));
		head = 12'($urandom_range(4095));
		if (chain_heads.size() != 0) begin
			slot = $urandom_range(chain_heads.size() - 1);
			head = chain_heads[slot];
			len  = board.trace_chain(head, tail);
		end

		if (pick < 15) begin
			// start a new chain
			rq.func = fcce_pkg::FN_ALLOC;
			case ($urandom_range(3))
				0: rq.cluster = 12'd1;
				1: rq.cluster = 12'($urandom_range(fcce_pkg::LINK_LIMIT, fcce_pkg::LINK_EOC));
				default: rq.cluster = 12'd0;
			endcase
			send_request(rq, res);
			if (res.st == fcce_pkg::ST_OK) chain_heads.push_back(res.word);
		end else if (pick < 30) begin
			// extend a chain at its end
			if ($urandom_range(1)) begin
				rq.func    = fcce_pkg::FN_ALLOC;
				rq.cluster = tail;
			end else begin
				rq.func    = fcce_pkg::FN_WALK;
				rq.cluster = head;
				rq.steps   = 12'(len + $urandom_range(1, 3));
				rq.grow    = 1'b1;
			end
			send_request(rq, res);
		end else if (pick < 50) begin
			rq.func    = fcce_pkg::FN_WALK;
			rq.cluster = head;
			rq.steps   = 12'($urandom_range(len + 2));
			send_request(rq, res);
		end else if (pick < 60) begin
			rq.func = fcce_pkg::FN_READ;
			if ($urandom_range(1)) rq.cluster = $urandom_range(1) ? head : tail;
			send_request(rq, res);
		end else if (pick < 70) begin
			rq.func    = fcce_pkg::FN_FREE;
			rq.cluster = head;
			chain_heads.delete(slot);
			send_request(rq, res);
		end else if (pick < 80) begin
			// overwrite links, in chains or anywhere
			rq.func = fcce_pkg::FN_WRITE;
			if ($urandom_range(1)) rq.cluster = $urandom_range(1) ? head : tail;
			case ($urandom_range(3))
				0: rq.word = 12'd0;
				1: rq.word = fcce_pkg::LINK_EOC;
				2: rq.word = 12'($urandom_range(2, 12'hFF7));
				default: rq.word = 12'($urandom_range(4095));
			endcase
			send_request(rq, res);
		end else if (pick < 87) begin
			rq.func = fcce_pkg::FN_WALK;
			rq.grow = 1'b0;
			send_request(rq, res);
		end else if (pick < 93) begin
			rq.func = fcce_pkg::FN_FREE;
			send_request(rq, res);
		end else if (pick < 97) begin
			rq.func = fcce_pkg::FN_ALLOC;
			send_request(rq, res);
		end else begin
			rq.func = 3'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
			send_request(rq, res);
		end
	endtask

	// Fill every allocatable entry, then hit exhaustion and the last free cluster
	task automatic exhaust_table();
		idle_pct = 0;
		// grow one chain from a fresh head until no free cluster is left
		directed_request(fcce_pkg::FN_WALK, 12'hFFF, 12'd0, 12'hFFF, 1'b1, 7'd0);
		directed_request(fcce_pkg::FN_WRITE, 12'd4080, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_ALLOC, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'hFFF, 12'd0, 12'd3, 1'b1, 7'd2);
		directed_request(fcce_pkg::FN_WRITE, 12'd100, 12'hFFF, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'd100, 12'd0, 12'd1, 1'b1, 7'h40);
		directed_request(fcce_pkg::FN_WRITE, 12'd4079, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_ALLOC, 12'd0, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WRITE, 12'd4079, 12'd0, 12'd0, 1'b0, 7'd0);
		directed_request(fcce_pkg::FN_WALK, 12'hFF9, 12'd0, 12'd0, 1'b1, 7'h7F);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// hold off until the table clear after reset is over
		do @(posedge clk); while (busy !== 1'b0);

		idle_pct = 0;
		directed_part();

		write_registers(16'd0, 16'd1);
		idle_pct = 0;
		repeat (350) random_item();

		write_registers(16'hFFFF, 16'd128);
		idle_pct = 82;
		repeat (350) random_item();

		write_registers(16'($urandom_range(65535)), 16'($urandom_range(65535)));
		idle_pct = 25;
		repeat (350) random_item();

		// all ones in both registers: addresses wrap
		write_registers(16'hFFFF, 16'hFFFF);
		idle_pct = 0;
		repeat (350) random_item();

		// zero sectors per cluster, through the masked upper bits
		write_registers(16'($urandom_range(65535)), 16'h0100);
		exhaust_table();

		wait_all_results();
		repeat (20) @(posedge clk);
		if (board.mismatches == 0 && board.pending_results.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#(1_000_000_000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
